[design/ptk_pkg.sv]
`default_nettype none

package ptk_pkg;

  // One text byte as it arrives
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_in_text;
  } in_item_t;

  // One result: a token byte or the empty end marker
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] token_class;
    logic       token_end;
    logic       text_end;
  } out_item_t;

  // Result slots for one text byte; one byte causes at most three results
  localparam int unsigned MAX_RES = 4;

  // Results of one byte, handed from the step logic to the result register
  typedef struct packed {
    logic [2:0]                cnt;
    out_item_t [MAX_RES-1:0]   res;
  } bundle_t;

  // Token classes
  localparam logic [1:0] CLS_CONTR  = 2'd0;
  localparam logic [1:0] CLS_LETTER = 2'd1;
  localparam logic [1:0] CLS_DIGIT  = 2'd2;
  localparam logic [1:0] CLS_OTHER  = 2'd3;

  // Pending contraction: none, apostrophe seen, apostrophe plus r/v/l seen
  localparam logic [1:0] Q_NONE = 2'd0;
  localparam logic [1:0] Q_ONE  = 2'd1;
  localparam logic [1:0] Q_TWO  = 2'd2;

  localparam logic [7:0] APOS = 8'h27;

  function automatic out_item_t mk_res(input logic [7:0] b, input logic v,
                                       input logic [1:0] cls, input logic e);
    out_item_t r;
    r.out_byte    = b;
    r.byte_valid  = v;
    r.token_class = cls;
    r.token_end   = e;
    r.text_end    = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

[design/ptk_skid.sv]
`default_nettype none

// Input register with a skid entry; in_ready comes straight from a flop.
module ptk_skid (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ptk_pkg::in_item_t in_item,
  input  wire logic              pop,
  output logic                   stage_valid,
  output ptk_pkg::in_item_t      stage_item
);

  logic              main_valid_r, main_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  ptk_pkg::in_item_t main_r, main_nxt;
  ptk_pkg::in_item_t skid_r, skid_nxt;
  logic              in_xfer;
  logic              main_open;

  assign in_ready    = !skid_valid_r;
  assign in_xfer     = in_valid && in_ready;
  assign main_open   = !main_valid_r || pop;
  assign stage_valid = main_valid_r;
  assign stage_item  = main_r;

  // Refill the stage from the skid entry first, else from the port
  always_comb begin
    main_valid_nxt = main_valid_r;
    main_nxt       = main_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (main_open) begin
      main_valid_nxt = skid_valid_r || in_xfer;
      main_nxt       = skid_valid_r ? skid_r : in_item;
      skid_valid_nxt = 1'b0;
    end else if (in_xfer) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

`ifndef SYNTHESIS
  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry holds data while stage is empty");
`endif

endmodule

`default_nettype wire

[design/ptk_step.sv]
`default_nettype none

// Token state and the per-byte classification logic.
module ptk_step (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire ptk_pkg::in_item_t stage_item,
  output ptk_pkg::bundle_t       bundle
);

  typedef struct packed {
    logic                emit;
    ptk_pkg::out_item_t  r;
    logic                start_q;
    logic                hv;
    logic [7:0]          hb;
    logic [1:0]          hc;
  } plain_t;

  logic [7:0] held_byte_r, held_byte_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic [1:0] run_class_r, run_class_nxt;
  logic [7:0] quote_byte_r, quote_byte_nxt;
  logic [1:0] quote_cnt_r, quote_cnt_nxt;

  logic [7:0] c;
  logic [7:0] lc;
  logic [7:0] need;
  logic       ws;
  logic       eot;
  logic [2:0] n;
  plain_t     pb;
  ptk_pkg::out_item_t [ptk_pkg::MAX_RES-1:0] res;

  // A kept byte with no contraction pending
  function automatic plain_t plain_byte(input logic [7:0] b, input logic hv,
                                        input logic [7:0] hb, input logic [1:0] hc);
    plain_t     p;
    logic [1:0] cls;
    p         = '0;
    p.hb      = hb;
    p.hc      = hc;
    p.emit    = hv;
    if (b == ptk_pkg::APOS && !(hv && hc == ptk_pkg::CLS_OTHER)) begin
      p.r       = ptk_pkg::mk_res(hb, 1'b1, hc, 1'b1);
      p.start_q = 1'b1;
      p.hv      = 1'b0;
    end else begin
      if (b inside {["a":"z"]}) cls = ptk_pkg::CLS_LETTER;
      else if (b inside {["0":"9"]}) cls = ptk_pkg::CLS_DIGIT;
      else cls = ptk_pkg::CLS_OTHER;
      p.r  = ptk_pkg::mk_res(hb, 1'b1, hc,
                             !(cls == hc && cls != ptk_pkg::CLS_DIGIT));
      p.hv = 1'b1;
      p.hb = b;
      p.hc = cls;
    end
    return p;
  endfunction

  assign c   = stage_item.in_byte;
  assign eot = stage_item.last_in_text;
  assign ws  = (c == 8'h20) || (c inside {[8'h09:8'h0D]});
  assign lc  = (c inside {["A":"Z"]}) ? c + 8'd32 : c;

  // Results of one byte and the state it leaves
  always_comb begin
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    run_class_nxt  = run_class_r;
    quote_byte_nxt = quote_byte_r;
    quote_cnt_nxt  = ptk_pkg::Q_NONE;
    res            = '0;
    n              = 3'd0;
    need           = (quote_byte_r == "l") ? "l" : "e";
    pb             = '0;

    case (quote_cnt_r)
      ptk_pkg::Q_ONE: begin
        if (ws) begin
          res[n[1:0]] = ptk_pkg::mk_res(ptk_pkg::APOS, 1'b1, ptk_pkg::CLS_OTHER, 1'b1);
          n = n + 3'd1;
        end else if (lc inside {"s", "t", "m", "d"}) begin
          res[n[1:0]] = ptk_pkg::mk_res(ptk_pkg::APOS, 1'b1, ptk_pkg::CLS_CONTR, 1'b0);
          n = n + 3'd1;
          res[n[1:0]] = ptk_pkg::mk_res(lc, 1'b1, ptk_pkg::CLS_CONTR, 1'b1);
          n = n + 3'd1;
        end else if (lc inside {"r", "v", "l"}) begin
          quote_byte_nxt = lc;
          quote_cnt_nxt  = ptk_pkg::Q_TWO;
        end else begin
          // failed contraction: apostrophe opens an other run
          pb = plain_byte(lc, 1'b1, ptk_pkg::APOS, ptk_pkg::CLS_OTHER);
          if (pb.emit) begin
            res[n[1:0]] = pb.r;
            n = n + 3'd1;
          end
          held_valid_nxt = pb.hv;
          held_byte_nxt  = pb.hb;
          run_class_nxt  = pb.hc;
          if (pb.start_q) quote_cnt_nxt = ptk_pkg::Q_ONE;
        end
      end
      ptk_pkg::Q_TWO: begin
        if (!ws && lc == need) begin
          res[n[1:0]] = ptk_pkg::mk_res(ptk_pkg::APOS, 1'b1, ptk_pkg::CLS_CONTR, 1'b0);
          n = n + 3'd1;
          res[n[1:0]] = ptk_pkg::mk_res(quote_byte_r, 1'b1, ptk_pkg::CLS_CONTR, 1'b0);
          n = n + 3'd1;
          res[n[1:0]] = ptk_pkg::mk_res(lc, 1'b1, ptk_pkg::CLS_CONTR, 1'b1);
          n = n + 3'd1;
        end else begin
          // apostrophe stands alone, the held r/v/l starts a letter run
          res[n[1:0]] = ptk_pkg::mk_res(ptk_pkg::APOS, 1'b1, ptk_pkg::CLS_OTHER, 1'b1);
          n = n + 3'd1;
          if (ws) begin
            res[n[1:0]] = ptk_pkg::mk_res(quote_byte_r, 1'b1, ptk_pkg::CLS_LETTER, 1'b1);
            n = n + 3'd1;
            held_valid_nxt = 1'b0;
            held_byte_nxt  = quote_byte_r;
            run_class_nxt  = ptk_pkg::CLS_LETTER;
          end else begin
            pb = plain_byte(lc, 1'b1, quote_byte_r, ptk_pkg::CLS_LETTER);
            if (pb.emit) begin
              res[n[1:0]] = pb.r;
              n = n + 3'd1;
            end
            held_valid_nxt = pb.hv;
            held_byte_nxt  = pb.hb;
            run_class_nxt  = pb.hc;
            if (pb.start_q) quote_cnt_nxt = ptk_pkg::Q_ONE;
          end
        end
      end
      default: begin
        if (ws) begin
          if (held_valid_r) begin
            res[n[1:0]] = ptk_pkg::mk_res(held_byte_r, 1'b1, run_class_r, 1'b1);
            n = n + 3'd1;
          end
          held_valid_nxt = 1'b0;
        end else begin
          pb = plain_byte(lc, held_valid_r, held_byte_r, run_class_r);
          if (pb.emit) begin
            res[n[1:0]] = pb.r;
            n = n + 3'd1;
          end
          held_valid_nxt = pb.hv;
          held_byte_nxt  = pb.hb;
          run_class_nxt  = pb.hc;
          if (pb.start_q) quote_cnt_nxt = ptk_pkg::Q_ONE;
        end
      end
    endcase

    // End of text: flush everything pending and return to reset state
    if (eot) begin
      if (quote_cnt_nxt == ptk_pkg::Q_ONE) begin
        res[n[1:0]] = ptk_pkg::mk_res(ptk_pkg::APOS, 1'b1, ptk_pkg::CLS_OTHER, 1'b1);
        n = n + 3'd1;
      end else if (quote_cnt_nxt == ptk_pkg::Q_TWO) begin
        res[n[1:0]] = ptk_pkg::mk_res(ptk_pkg::APOS, 1'b1, ptk_pkg::CLS_OTHER, 1'b1);
        n = n + 3'd1;
        res[n[1:0]] = ptk_pkg::mk_res(quote_byte_nxt, 1'b1, ptk_pkg::CLS_LETTER, 1'b1);
        n = n + 3'd1;
      end
      if (held_valid_nxt) begin
        res[n[1:0]] = ptk_pkg::mk_res(held_byte_nxt, 1'b1, run_class_nxt, 1'b1);
        n = n + 3'd1;
      end
      if (n == 3'd0) begin
        res[n[1:0]] = ptk_pkg::mk_res(8'd0, 1'b0, ptk_pkg::CLS_CONTR, 1'b0);
        n = n + 3'd1;
      end
      res[n[1:0] - 2'd1].text_end = 1'b1;
      held_byte_nxt  = 8'd0;
      held_valid_nxt = 1'b0;
      run_class_nxt  = 2'd0;
      quote_byte_nxt = 8'd0;
      quote_cnt_nxt  = ptk_pkg::Q_NONE;
    end

    bundle.cnt = n;
    bundle.res = res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_byte_r  <= 8'd0;
      held_valid_r <= 1'b0;
      run_class_r  <= 2'd0;
      quote_byte_r <= 8'd0;
      quote_cnt_r  <= ptk_pkg::Q_NONE;
    end else if (take) begin
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      run_class_r  <= run_class_nxt;
      quote_byte_r <= quote_byte_nxt;
      quote_cnt_r  <= quote_cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_quote_cnt_legal: assert property (@(posedge clk) disable iff (!rst_n)
    quote_cnt_r != 2'd3)
    else $error("contraction tracker in unused code");

  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && stage_item.last_in_text) |=> (!held_valid_r && quote_cnt_r == ptk_pkg::Q_NONE))
    else $error("state not cleared after end of text");
`endif

endmodule

`default_nettype wire

[design/ptk_serial.sv]
`default_nettype none

// Result register: holds one byte's results and hands them out one per cycle while out_ready is high.
module ptk_serial (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire ptk_pkg::bundle_t  bundle,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ptk_pkg::out_item_t     out_item
);

  ptk_pkg::out_item_t [ptk_pkg::MAX_RES-1:0] res_r, res_nxt;
  logic [2:0] rem_r, rem_nxt;
  logic       out_xfer;

  assign out_valid = rem_r != 3'd0;
  assign out_item  = res_r[0];
  assign out_xfer  = out_valid && out_ready;
  assign free      = (rem_r == 3'd0) || (rem_r == 3'd1 && out_ready);

  // Load a fresh set, or shift the next result to the head
  always_comb begin
    res_nxt = res_r;
    rem_nxt = rem_r;
    if (load) begin
      res_nxt = bundle.res;
      rem_nxt = bundle.cnt;
    end else if (out_xfer) begin
      for (int i = 0; i < ptk_pkg::MAX_RES - 1; i++) begin
        res_nxt[i] = res_r[i+1];
      end
      rem_nxt = rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
    end else begin
      rem_r <= rem_nxt;
    end
    res_r <= res_nxt;
  end

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 3'd4)
    else $error("result count out of range");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("result register overwritten");

  a_pop_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && !load) |=> rem_r == $past(rem_r) - 3'd1)
    else $error("result count did not drop on transfer");
`endif

endmodule

`default_nettype wire

[design/text_pretokenizer.sv]
`default_nettype none

// Text pre-tokenizer for a byte-pair encoder front end.
// Input channel (in_valid/in_ready/in_item): one raw text byte per transfer,
// with last_in_text set on the last byte of a text.
// Result channel (out_valid/out_ready/out_item): kept bytes, lowercased, each
// tagged with token class and token end; text_end marks a text's last result.
// A byte gives zero to three results; an end of text with nothing pending
// gives one empty result (byte_valid low).
// A byte taken from the input channel waits in the input register, then its
// results enter the result register, from which the first one can transfer.
// Throughput: one byte per cycle while out_ready is high and each byte gives
// at most one result; more results hold the result register until all transfer.
// in_ready comes from a flop (two-entry input register with skid), so a new
// byte is taken while a finished result waits. When out_ready is low the
// results hold steady and input stops after two bytes are buffered.
// Reset (rst_n low at a clock edge) empties both registers and clears all
// token state.
module text_pretokenizer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ptk_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ptk_pkg::out_item_t      out_item
);

  logic              stage_valid;
  ptk_pkg::in_item_t stage_item;
  logic              free;
  logic              take;
  ptk_pkg::bundle_t  bundle;

  // Stage byte moves into the result register once it can take a full set
  assign take = stage_valid && free;

  ptk_skid u_skid (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .pop         (take),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  ptk_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .stage_item (stage_item),
    .bundle     (bundle)
  );

  ptk_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .bundle    (bundle),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
